/* sv/ibrc_pkg.sv */
// Package for the iBus frame decoder: frame layout constants and cell control types.
// Depends on nothing; every module of the decoder imports it.
package ibrc_pkg;

    localparam int unsigned BODY_BYTES    = 30;
    localparam int unsigned PAYLOAD_BYTES = 28;
    localparam int unsigned CHANNELS      = 14;
    // The last body byte is taken straight from the input, so the row keeps one fewer.
    localparam int unsigned STORE_CELLS   = BODY_BYTES - 1;

    localparam logic [7:0]  HDR_FIRST     = 8'h20;
    localparam logic [7:0]  HDR_SECOND    = 8'h40;
    localparam logic [15:0] SUM_START     = 16'hFFFF - 16'h0020 - 16'h0040;

    localparam logic [4:0]  LAST_BODY     = 5'(BODY_BYTES - 1);
    localparam logic [4:0]  PAYLOAD_COUNT = 5'(PAYLOAD_BYTES);
    localparam logic [3:0]  LAST_CHANNEL  = 4'(CHANNELS - 1);

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] chan_val_t;

    // Control for the channel output row: parallel load or one step toward the port.
    typedef struct packed {
        logic load;
        logic shift;
    } chan_ctl_t;

endpackage

/* sv/ibrc_byte_cell.sv */
// One cell of the body byte row: holds a byte and passes it to the next cell on a shift.
// Depends on ibrc_pkg.
module ibrc_byte_cell
    import ibrc_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  byte_t byte_in,
    output byte_t byte_out
);

    byte_t byte_reg;
    byte_t byte_next;

    always_comb
    begin
        byte_next = shift ? byte_in : byte_reg;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;

endmodule

/* sv/ibrc_chan_cell.sv */
// One cell of the channel output row: loads a channel value from the byte row or
// takes its upstream neighbor's value as results drain. Depends on ibrc_pkg.
module ibrc_chan_cell
    import ibrc_pkg::*;
(
    input  logic      clk,
    input  chan_ctl_t ctl,
    input  byte_t     low_byte,
    input  byte_t     high_byte,
    input  chan_val_t shift_in,
    output chan_val_t value
);

    chan_val_t value_reg;
    chan_val_t value_next;

    always_comb
    begin
        if (ctl.load)
        begin
            value_next = {high_byte, low_byte};
        end
        else if (ctl.shift)
        begin
            value_next = shift_in;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* sv/ibus_rc_frame_decoder.sv */
// Top level of the iBus frame decoder: header hunt, checksum, byte row and channel row.
// Depends on ibrc_pkg, ibrc_byte_cell and ibrc_chan_cell.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata[7:0] rx_byte
//  m_*     | out | m_tvalid/m_tready  | m_tdata[3:0] channel_index, [19:4] channel_value,
//          |     |                    | [23:20] zero; m_tlast last_channel
//
// One byte is taken per cycle; a good frame yields 14 results at one per cycle.
// The channel row holds one frame while it drains, so the input stalls only when a
// frame's last byte arrives while the previous frame's results are still waiting.
// Reset (rst_n low, asynchronous) returns the decoder to header hunting with the
// channel row empty. Stalls on m_tready hold the current result on the port.
module ibus_rc_frame_decoder
    import ibrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] channel_index, [19:4] channel_value, [23:20] zero
    output logic        m_tlast
);

    logic        in_frame_reg, in_frame_next;
    logic [4:0]  body_cnt_reg, body_cnt_next;
    byte_t       prev_reg, prev_next;
    logic [15:0] sum_reg, sum_next;
    logic        busy_reg, busy_next;
    logic [3:0]  chan_reg, chan_next;

    logic      s_accept;
    logic      m_accept;
    logic      frame_end;
    logic      sum_match;
    logic      load;
    logic      store_shift;
    chan_ctl_t chan_ctl;

    byte_t     store [STORE_CELLS];
    chan_val_t drain [CHANNELS];

    assign frame_end   = in_frame_reg && (body_cnt_reg == LAST_BODY);
    assign s_tready    = !(frame_end && busy_reg);
    assign s_accept    = s_tvalid && s_tready;
    assign m_accept    = m_tvalid && m_tready;
    // The checksum is byte 28 (the newest cell, at the row head) and the incoming byte 29.
    assign sum_match   = ({s_tdata, store[0]} == sum_reg);
    assign load        = s_accept && frame_end && sum_match;
    assign store_shift = s_accept && in_frame_reg && !frame_end;

    assign chan_ctl.load  = load;
    assign chan_ctl.shift = m_accept;

    // Byte row: cell 0 takes the newest byte, so body byte j sits in cell 28 - j at frame end.
    genvar gi;
    generate
        for (gi = 0; gi < STORE_CELLS; gi++)
        begin : g_store
            if (gi == 0)
            begin : g_head
                ibrc_byte_cell u_cell (
                    .clk      (clk),
                    .shift    (store_shift),
                    .byte_in  (s_tdata),
                    .byte_out (store[gi])
                );
            end
            else
            begin : g_body
                ibrc_byte_cell u_cell (
                    .clk      (clk),
                    .shift    (store_shift),
                    .byte_in  (store[gi-1]),
                    .byte_out (store[gi])
                );
            end
        end

        for (gi = 0; gi < CHANNELS; gi++)
        begin : g_chan
            if (gi == CHANNELS - 1)
            begin : g_tail
                ibrc_chan_cell u_cell (
                    .clk       (clk),
                    .ctl       (chan_ctl),
                    .low_byte  (store[STORE_CELLS - 1 - 2*gi]),
                    .high_byte (store[STORE_CELLS - 2 - 2*gi]),
                    .shift_in  ('0),
                    .value     (drain[gi])
                );
            end
            else
            begin : g_mid
                ibrc_chan_cell u_cell (
                    .clk       (clk),
                    .ctl       (chan_ctl),
                    .low_byte  (store[STORE_CELLS - 1 - 2*gi]),
                    .high_byte (store[STORE_CELLS - 2 - 2*gi]),
                    .shift_in  (drain[gi+1]),
                    .value     (drain[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        in_frame_next = in_frame_reg;
        body_cnt_next = body_cnt_reg;
        prev_next     = prev_reg;
        sum_next      = sum_reg;
        busy_next     = busy_reg;
        chan_next     = chan_reg;

        if (s_accept)
        begin
            prev_next = s_tdata;
            if (in_frame_reg)
            begin
                if (body_cnt_reg < PAYLOAD_COUNT)
                begin
                    sum_next = sum_reg - {8'd0, s_tdata};
                end
                if (frame_end)
                begin
                    in_frame_next = 1'b0;
                    body_cnt_next = '0;
                    sum_next      = SUM_START;
                end
                else
                begin
                    body_cnt_next = body_cnt_reg + 5'd1;
                end
            end
            else if ((s_tdata == HDR_SECOND) && (prev_reg == HDR_FIRST))
            begin
                in_frame_next = 1'b1;
                body_cnt_next = '0;
                sum_next      = SUM_START;
            end
        end

        if (m_accept)
        begin
            if (chan_reg == LAST_CHANNEL)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                chan_next = chan_reg + 4'd1;
            end
        end

        if (load)
        begin
            busy_next = 1'b1;
            chan_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            body_cnt_reg <= '0;
            prev_reg     <= '0;
            sum_reg      <= SUM_START;
            busy_reg     <= 1'b0;
            chan_reg     <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            body_cnt_reg <= body_cnt_next;
            prev_reg     <= prev_next;
            sum_reg      <= sum_next;
            busy_reg     <= busy_next;
            chan_reg     <= chan_next;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = {4'd0, drain[0], chan_reg};
    assign m_tlast  = (chan_reg == LAST_CHANNEL);

`ifndef SYNTHESIS
    // A new frame must never overwrite results that are still draining.
    a_load_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy_reg)
        else $error("channel row loaded while busy");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (body_cnt_reg <= LAST_BODY))
        else $error("body count out of range");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (body_cnt_reg == 5'd0))
        else $error("body count not cleared while hunting");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("result after last channel");
`endif

endmodule

/* verif/tb_top.sv */
// Testbench for ibus_rc_frame_decoder: byte requests go in, a scoreboard predicts decoded channels.
// Depends on ibrc_pkg and the decoder RTL only; random frames, noise and stalls come from $urandom.
module tb_top
    import ibrc_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int TOTAL_ITEMS   = 420;
    localparam int HOLD_START    = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 50;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_HEADERS} fill_t;
    typedef enum {LEAD_PAIR, LEAD_SECOND} lead_t;

    typedef struct packed {
        logic [3:0] index;
        chan_val_t  value;
        logic       last;
    } chan_result_t;

    class frame_scoreboard;
        bit           in_frame;
        int unsigned  body_count;
        byte_t        last_rx;
        byte_t        body[BODY_BYTES];
        logic [15:0]  sum;
        chan_result_t expected_channels[$];
        int           errors;
        int           frames_ok;
        int           frames_bad;
        int           checked;

        function new();
            in_frame   = 0;
            body_count = 0;
            last_rx    = '0;
            sum        = SUM_START;
            errors     = 0;
            frames_ok  = 0;
            frames_bad = 0;
            checked    = 0;
        endfunction

        // Called for every accepted input request.
        function void note_byte(byte_t b);
            chan_result_t r;
            logic [15:0]  rx_sum;
            if (in_frame)
            begin
                body[body_count] = b;
                if (body_count < PAYLOAD_BYTES)
                    sum = sum - 16'(b);
                if (body_count == BODY_BYTES - 1)
                begin
                    rx_sum = {body[PAYLOAD_BYTES + 1], body[PAYLOAD_BYTES]};
                    if (rx_sum == sum)
                    begin
                        for (int k = 0; k < CHANNELS; k++)
                        begin
                            r.index = 4'(k);
                            r.value = {body[2 * k + 1], body[2 * k]};
                            r.last  = (k == CHANNELS - 1);
                            expected_channels.push_back(r);
                        end
                        frames_ok++;
                    end
                    else
                        frames_bad++;
                    in_frame   = 0;
                    body_count = 0;
                    sum        = SUM_START;
                end
                else
                    body_count++;
            end
            else if (b == HDR_SECOND && last_rx == HDR_FIRST)
            begin
                in_frame   = 1;
                body_count = 0;
                sum        = SUM_START;
            end
            last_rx = b;
        endfunction

        function void check_channel(logic [23:0] data, logic last);
            chan_result_t e;
            if (expected_channels.size() == 0)
            begin
                $error("unexpected channel result: tdata=%h tlast=%b", data, last);
                errors++;
                return;
            end
            e = expected_channels.pop_front();
            checked++;
            if (data[3:0] !== e.index)
            begin
                $error("channel_index: expected %0d, actual %0d", e.index, data[3:0]);
                errors++;
            end
            if (data[19:4] !== e.value)
            begin
                $error("channel_value: expected %h, actual %h", e.value, data[19:4]);
                errors++;
            end
            if (data[23:20] !== 4'h0)
            begin
                $error("tdata padding: expected 0, actual %h", data[23:20]);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last_channel: expected %b, actual %b", e.last, last);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_channels.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [3:0] channel_index, [19:4] channel_value, [23:20] zero
    logic        m_tlast;

    frame_scoreboard sb;
    byte_t           stim_q[$];
    int              bytes_sent;
    int              cycles;

    ibus_rc_frame_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push_noise(int n);
        byte_t b;
        for (int i = 0; i < n; i++)
        begin
            b = byte_t'($urandom);
            // Keep noise from opening frames on its own; header hunting is covered directly.
            if (b == HDR_SECOND)
                b = 8'h41;
            stim_q.push_back(b);
        end
    endfunction

    function automatic void push_frame(fill_t fill, lead_t lead, bit good, bit end_in_first);
        byte_t       pay[PAYLOAD_BYTES];
        logic [15:0] s;
        logic [15:0] cks;
        s = SUM_START;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            case (fill)
                FILL_ZERO:    pay[i] = 8'h00;
                FILL_ONES:    pay[i] = 8'hFF;
                FILL_HEADERS: pay[i] = (i % 4 == 0) ? HDR_FIRST :
                                       (i % 4 == 1) ? HDR_SECOND : byte_t'($urandom);
                default:      pay[i] = byte_t'($urandom);
            endcase
            s = s - 16'(pay[i]);
        end
        cks = good ? s : s ^ 16'($urandom_range(1, 16'hFFFF));
        // A valid checksum never has 0x20 in its high byte, so this frame always fails.
        if (end_in_first)
            cks = {HDR_FIRST, byte_t'($urandom)};
        if (lead == LEAD_PAIR)
            stim_q.push_back(HDR_FIRST);
        stim_q.push_back(HDR_SECOND);
        foreach (pay[i])
            stim_q.push_back(pay[i]);
        stim_q.push_back(cks[7:0]);
        stim_q.push_back(cks[15:8]);
    endfunction

    function automatic void build_stimulus();
        int target;
        int kind;
        // Header hunt from reset: a lone 0x40, extremes, then a repeated first header byte.
        stim_q.push_back(HDR_SECOND);
        stim_q.push_back(8'h00);
        stim_q.push_back(8'hFF);
        stim_q.push_back(HDR_FIRST);
        push_frame(FILL_ZERO, LEAD_PAIR, 1, 0);
        push_frame(FILL_ONES, LEAD_PAIR, 1, 0);
        push_frame(FILL_HEADERS, LEAD_PAIR, 1, 0);
        push_frame(FILL_RANDOM, LEAD_PAIR, 0, 1);
        push_frame(FILL_RANDOM, LEAD_SECOND, 1, 0);

        target = TOTAL_ITEMS;
        while (stim_q.size() < target)
        begin
            kind = $urandom_range(0, 11);
            case (kind)
                0, 1, 2, 3, 4: push_frame(FILL_RANDOM, LEAD_PAIR, 1, 0);
                5:             push_frame(FILL_HEADERS, LEAD_PAIR, 1, 0);
                6:             push_frame($urandom_range(0, 1) ? FILL_ZERO : FILL_ONES,
                                          LEAD_PAIR, 1, 0);
                7:             push_frame(FILL_RANDOM, LEAD_PAIR, 0, 0);
                8:             push_noise($urandom_range(1, 8));
                9:
                begin
                    push_frame(FILL_RANDOM, LEAD_PAIR, 0, 1);
                    push_frame(FILL_RANDOM, LEAD_SECOND, 1, 0);
                end
                10:
                begin
                    // Cut-off frame: the next header ends up inside its body.
                    stim_q.push_back(HDR_FIRST);
                    stim_q.push_back(HDR_SECOND);
                    push_noise($urandom_range(1, BODY_BYTES - 1));
                end
                default:
                begin
                    push_noise($urandom_range(1, 3));
                    push_frame(FILL_RANDOM, LEAD_PAIR, 1, 0);
                end
            endcase
        end
    endfunction

    task automatic send_bytes();
        byte_t b;
        int    burst;
        int    gap;
        while (stim_q.size() > 0)
        begin
            burst = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 24);
            while (burst > 0 && stim_q.size() > 0)
            begin
                b = stim_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= b;
                do
                    @(posedge clk);
                while (!s_tready);
                sb.note_byte(b);
                bytes_sent++;
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // Receiver: changing stall patterns, plus one long hold-off that backs the block up.
    initial
    begin
        int rx_cyc;
        rx_cyc = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cyc++;
            if (rx_cyc >= HOLD_START && rx_cyc < HOLD_START + HOLD_CYCLES)
                m_tready <= 1'b0;
            else
                case ((rx_cyc / 40) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (rx_cyc % 3 != 0);
                endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_channel(m_tdata, m_tlast);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        sb         = new();
        bytes_sent = 0;
        cycles     = 0;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        build_stimulus();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_bytes();
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
        begin
            $error("%0d channel results never arrived", sb.outstanding());
            sb.errors++;
        end
        $display("Sent %0d bytes: %0d frames decoded, %0d frames rejected on checksum.",
                 bytes_sent, sb.frames_ok, sb.frames_bad);
        $display("Checked %0d channel results under random stalls and a long hold-off.",
                 sb.checked);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
